[hdl/fragment_reassembly_tracker_assert.svh]
// assertion macros for the reassembly tracker
`ifndef FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// same-cycle implication
`define FRT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/fra_pkg.sv]
package fra_pkg;

   localparam int MAX_PARTS    = 64;
   localparam int PART_W       = $clog2(MAX_PARTS);
   localparam int COUNT_W      = PART_W + 1;
   localparam int PACKET_BYTES = 1024;
   localparam int POS_W        = $clog2(PACKET_BYTES) + 1;
   localparam int LEN_W        = $clog2(PACKET_BYTES);
   localparam int SUM_W        = 16;
   localparam int SESS_W       = 32;
   localparam int BYTE_W       = 8;
   localparam int LENGTH_BIAS  = 2;

   localparam int REQ_FIELDS_W = SESS_W + PART_W + BYTE_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 3 + COUNT_W + SUM_W + PART_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      STATUS_STORED    = 3'd0,
      STATUS_REJECTED  = 3'd1,
      STATUS_MISMATCH  = 3'd2,
      STATUS_COMPLETE  = 3'd3,
      STATUS_HEAD_ZERO = 3'd4,
      STATUS_NO_ENDING = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      VERDICT_OK        = 2'd0,
      VERDICT_HEAD_ZERO = 2'd1,
      VERDICT_NO_ENDING = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      SEQ_SCAN,
      SEQ_STORE,
      SEQ_READ,
      SEQ_ACC,
      SEQ_FINISH,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      verdict_type             verdict;
      logic [LEN_W-1:0]        length;
   } scan_result_type;

   typedef struct packed {
      logic                    en;
      logic [PART_W-1:0]       idx;
      logic [LEN_W-1:0]        length;
      verdict_type             verdict;
   } part_wr_type;

   typedef struct packed {
      logic                    present;
      logic [LEN_W-1:0]        length;
      verdict_type             verdict;
   } part_rd_type;

   typedef struct packed {
      logic [PART_W-1:0]       bad_part;
      logic [SUM_W-1:0]        assembly_length;
      logic [COUNT_W-1:0]      part_total;
      status_type              status;
   } result_type;

endpackage

[hdl/fra_scan.sv]
module fra_scan import fra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_en,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic               last_byte,
   output scan_result_type    scan_result
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       zero_run_ff, zero_run_in;
   logic [LEN_W-1:0] found_ff, found_in;
   logic [1:0]       head_ff, head_in;

   always_comb begin
      pos_in      = pos_ff;
      zero_run_in = zero_run_ff;
      found_in    = found_ff;
      head_in     = head_ff;
      if (pos_ff < POS_W'(PACKET_BYTES)) begin
         if (data_byte == '0) begin
            if (pos_ff < POS_W'(2)) begin
               head_in[pos_ff[0]] = 1'b1;
            end
            if (zero_run_ff != 2'd3) begin
               zero_run_in = zero_run_ff + 2'd1;
            end
            if (zero_run_in == 2'd3 && pos_ff >= POS_W'(3) && found_ff == '0) begin
               found_in = LEN_W'(pos_ff - POS_W'(1));
            end
         end else begin
            zero_run_in = '0;
         end
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      scan_result.length = found_in;
      if (head_in == 2'b11) begin
         scan_result.verdict = VERDICT_HEAD_ZERO;
      end else if (found_in == '0) begin
         scan_result.verdict = VERDICT_NO_ENDING;
      end else begin
         scan_result.verdict = VERDICT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_en && last_byte)) begin
         pos_ff      <= '0;
         zero_run_ff <= '0;
         found_ff    <= '0;
         head_ff     <= '0;
      end else if (byte_en) begin
         pos_ff      <= pos_in;
         zero_run_ff <= zero_run_in;
         found_ff    <= found_in;
         head_ff     <= head_in;
      end
   end

endmodule

[hdl/fra_part_mem.sv]
module fra_part_mem import fra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  part_wr_type        part_wr,
   input  logic               rd_en,
   input  logic [PART_W-1:0]  rd_addr,
   output part_rd_type        rd_data
);

   logic [MAX_PARTS-1:0] present_ff;
   logic [LEN_W-1:0]     length_mem [MAX_PARTS];
   verdict_type          verdict_mem [MAX_PARTS];
   part_rd_type          rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (part_wr.en) begin
         present_ff[part_wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (part_wr.en) begin
         length_mem[part_wr.idx]  <= part_wr.length;
         verdict_mem[part_wr.idx] <= part_wr.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.present <= present_ff[rd_addr];
         rd_data_ff.length  <= length_mem[rd_addr];
         rd_data_ff.verdict <= verdict_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fra_walk_seq.sv]
module fra_walk_seq import fra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               last_byte,
   input  logic [SESS_W-1:0]  packet_session,
   input  logic [PART_W-1:0]  part_number,
   input  logic               is_beginning,
   input  logic               is_ending,
   input  logic [SESS_W-1:0]  session_number,
   input  scan_result_type    scan_result,
   input  part_rd_type        rd_data,
   input  logic               out_free,
   output logic               req_ready,
   output part_wr_type        part_wr,
   output logic               rd_en,
   output logic [PART_W-1:0]  rd_addr,
   output logic               result_valid,
   output result_type         result
);

   seq_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [PART_W-1:0]   part_ff, part_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   verdict_type         verdict_ff, verdict_in;
   logic [COUNT_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PART_W-1:0]   bad_ff, bad_in;
   logic                bad_found_ff, bad_found_in;
   verdict_type         bad_verdict_ff, bad_verdict_in;
   logic                missing_ff, missing_in;
   status_type          status_ff, status_in;

   logic                take_last;
   logic                mismatch;
   logic                reject;
   logic [COUNT_W-1:0]  idx_next;
   logic [SUM_W-1:0]    add_b;
   logic [SUM_W-1:0]    add_out;

   assign take_last = req_fire && last_byte;
   assign mismatch  = packet_session != session_number;
   assign reject    = !is_ending && count_ff != '0
                      && {1'b0, part_number} >= count_ff;
   assign idx_next  = idx_ff + COUNT_W'(1);

   // shared accumulator adder
   assign add_b   = (state_ff == SEQ_FINISH) ? SUM_W'(LENGTH_BIAS) : SUM_W'(rd_data.length);
   assign add_out = sum_ff + add_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_SCAN: begin
            if (take_last) begin
               state_in = (mismatch || reject) ? SEQ_DONE : SEQ_STORE;
            end
         end
         SEQ_STORE:  state_in = (count_ff == '0) ? SEQ_DONE : SEQ_READ;
         SEQ_READ:   state_in = SEQ_ACC;
         SEQ_ACC:    state_in = (idx_next == count_ff) ? SEQ_FINISH : SEQ_READ;
         SEQ_FINISH: state_in = SEQ_DONE;
         SEQ_DONE: begin
            if (out_free) begin
               state_in = SEQ_SCAN;
            end
         end
         default:    state_in = SEQ_SCAN;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      part_in        = part_ff;
      len_in         = len_ff;
      verdict_in     = verdict_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      bad_in         = bad_ff;
      bad_found_in   = bad_found_ff;
      bad_verdict_in = bad_verdict_ff;
      missing_in     = missing_ff;
      status_in      = status_ff;
      case (state_ff)
         SEQ_SCAN: begin
            part_in    = part_number;
            len_in     = scan_result.length;
            verdict_in = scan_result.verdict;
            if (take_last) begin
               if (mismatch) begin
                  status_in = STATUS_MISMATCH;
               end else if (reject) begin
                  status_in = STATUS_REJECTED;
               end else begin
                  status_in = STATUS_STORED;
                  if (is_ending) begin
                     count_in = is_beginning ? COUNT_W'(1)
                                             : {1'b0, part_number} + COUNT_W'(1);
                  end
               end
            end
         end
         SEQ_STORE: begin
            idx_in       = '0;
            sum_in       = '0;
            bad_in       = '0;
            bad_found_in = 1'b0;
            missing_in   = 1'b0;
         end
         SEQ_ACC: begin
            idx_in = idx_next;
            if (!rd_data.present) begin
               missing_in = 1'b1;
            end else if (!bad_found_ff) begin
               if (rd_data.verdict != VERDICT_OK) begin
                  bad_found_in   = 1'b1;
                  bad_in         = idx_ff[PART_W-1:0];
                  bad_verdict_in = rd_data.verdict;
               end else begin
                  sum_in = add_out;
               end
            end
         end
         SEQ_FINISH: begin
            if (missing_ff) begin
               status_in = STATUS_STORED;
            end else if (bad_found_ff) begin
               status_in = (bad_verdict_ff == VERDICT_HEAD_ZERO) ? STATUS_HEAD_ZERO
                                                                 : STATUS_NO_ENDING;
            end else begin
               status_in = STATUS_COMPLETE;
               sum_in    = add_out;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      part_wr.en      = 1'b0;
      rd_en           = 1'b0;
      result_valid    = 1'b0;
      part_wr.idx     = part_ff;
      part_wr.length  = len_ff;
      part_wr.verdict = verdict_ff;
      rd_addr         = idx_ff[PART_W-1:0];
      case (state_ff)
         SEQ_SCAN:  req_ready    = 1'b1;
         SEQ_STORE: part_wr.en   = 1'b1;
         SEQ_READ:  rd_en        = 1'b1;
         SEQ_DONE:  result_valid = out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      result.status          = status_ff;
      result.part_total      = count_ff;
      result.assembly_length = (status_ff == STATUS_COMPLETE) ? sum_ff : '0;
      result.bad_part        = (status_ff == STATUS_HEAD_ZERO || status_ff == STATUS_NO_ENDING)
                               ? bad_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_SCAN;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff        <= part_in;
      len_ff         <= len_in;
      verdict_ff     <= verdict_in;
      idx_ff         <= idx_in;
      sum_ff         <= sum_in;
      bad_ff         <= bad_in;
      bad_found_ff   <= bad_found_in;
      bad_verdict_ff <= bad_verdict_in;
      missing_ff     <= missing_in;
      status_ff      <= status_in;
   end

endmodule

[hdl/fragment_reassembly_tracker.sv]
// Tracks the parts of one session's packet, one byte per transaction on the
// req channel. Each byte that is not the last of its part is taken without
// holding the req side. On the last byte the part is checked against the csr
// session and the known part count, stored with its verdict and scanned length
// if it passes, and one status transaction goes out on rsp. When the part
// count is known, the stored parts below it are walked through the part
// memory, each read in SEQ_READ and summed in SEQ_ACC. A last byte holds the
// req side until its status is handed to the output register, which also
// waits while the previous rsp transaction is still held. No clearing pass is
// needed after reset.
`include "fragment_reassembly_tracker_assert.svh"

module fragment_reassembly_tracker import fra_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // packet_session, part_number, data_byte, zero pad
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // is_beginning, is_ending
   input  logic [1:0]              req_tuser,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // status, part_total, assembly_length, bad_part
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    csr_wr_en,
   input  logic [SESS_W-1:0]       csr_wr_data
);

   logic [SESS_W-1:0]  session_ff;
   logic               rsp_tvalid_ff;
   result_type         rsp_result_ff;

   logic               req_fire;
   logic               out_free;
   logic [SESS_W-1:0]  packet_session;
   logic [PART_W-1:0]  part_number;
   logic [BYTE_W-1:0]  data_byte;
   scan_result_type    scan_result;
   part_wr_type        part_wr;
   part_rd_type        rd_data;
   logic               rd_en;
   logic [PART_W-1:0]  rd_addr;
   logic               result_valid;
   result_type         result;

   assign req_fire       = req_tvalid && req_tready;
   assign out_free       = !rsp_tvalid_ff || rsp_tready;
   assign packet_session = req_tdata[SESS_W-1:0];
   assign part_number    = req_tdata[SESS_W +: PART_W];
   assign data_byte      = req_tdata[SESS_W+PART_W +: BYTE_W];

   fra_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .byte_en     (req_fire),
      .data_byte   (data_byte),
      .last_byte   (req_tlast),
      .scan_result (scan_result)
   );

   fra_part_mem u_part_mem (
      .clock   (clock),
      .reset   (reset),
      .part_wr (part_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fra_walk_seq u_walk_seq (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .last_byte      (req_tlast),
      .packet_session (packet_session),
      .part_number    (part_number),
      .is_beginning   (req_tuser[0]),
      .is_ending      (req_tuser[1]),
      .session_number (session_ff),
      .scan_result    (scan_result),
      .rd_data        (rd_data),
      .out_free       (out_free),
      .req_ready      (req_tready),
      .part_wr        (part_wr),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .result_valid   (result_valid),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff <= '0;
      end else if (csr_wr_en) begin
         session_ff <= csr_wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (result_valid) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_result_ff.bad_part,
                                     rsp_result_ff.assembly_length,
                                     rsp_result_ff.part_total,
                                     rsp_result_ff.status});

   `FRT_ASSERT_NEXT(a_no_rsp_mid_part, req_fire && !req_tlast && !rsp_tvalid_ff, !rsp_tvalid_ff, "result raised by a byte that does not end its part")
   `FRT_ASSERT_IMPL(a_complete_fields, rsp_tvalid_ff && rsp_result_ff.status == STATUS_COMPLETE, rsp_result_ff.bad_part == '0 && rsp_result_ff.assembly_length >= SUM_W'(LENGTH_BIAS) && rsp_result_ff.part_total != '0, "complete status with inconsistent fields")
   `FRT_ASSERT_IMPL(a_total_range, rsp_tvalid_ff, rsp_result_ff.part_total <= COUNT_W'(MAX_PARTS), "part total beyond the part limit")

endmodule
